>>> src/lss_pkg.sv
package lss_pkg;

  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned MAX_COLUMNS = 1024;

  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned IDX_W  = 1;

  localparam int unsigned DOWN_W   = 21;
  localparam int unsigned BORDER_W = 12;
  localparam int unsigned PAIRS_W  = 21;
  localparam int unsigned RES_W    = DOWN_W + BORDER_W + PAIRS_W;
  localparam int unsigned TDATA_W  = ((RES_W + 7) / 8) * 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 11'd16;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 11'd16;

  // one classified cell, front to back
  typedef struct packed {
    logic             spin;
    logic [COL_W-1:0] col;
    logic             first_col;
    logic             first_row;
    logic             border;
    logic             last;
  } cell_t;

endpackage

>>> src/lss_front.sv
module lss_front import lss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_spin_i,
  output logic             cell_valid_o,
  input  logic             cell_ready_i,
  output cell_t            cell_o
);

  logic [CFG_W-1:0] row_count_q, col_count_q;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [CFG_W-1:0] last_row_w, last_col_w;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;
  logic             row_end, lattice_end, accept;

  always_comb begin
    if (row_count_q < CFG_W'(2)) begin
      last_row_w = CFG_W'(1);
    end else if (row_count_q > CFG_W'(MAX_ROWS)) begin
      last_row_w = CFG_W'(MAX_ROWS - 1);
    end else begin
      last_row_w = row_count_q - CFG_W'(1);
    end
    if (col_count_q < CFG_W'(2)) begin
      last_col_w = CFG_W'(1);
    end else if (col_count_q > CFG_W'(MAX_COLUMNS)) begin
      last_col_w = CFG_W'(MAX_COLUMNS - 1);
    end else begin
      last_col_w = col_count_q - CFG_W'(1);
    end
    last_row = last_row_w[ROW_W-1:0];
    last_col = last_col_w[COL_W-1:0];
  end

  assign row_end     = col_q >= last_col;
  assign lattice_end = row_end && (row_q >= last_row);
  assign in_ready_o  = cell_ready_i;
  assign accept      = in_valid_i && cell_ready_i;

  assign cell_valid_o     = in_valid_i;
  assign cell_o.spin      = in_spin_i;
  assign cell_o.col       = col_q;
  assign cell_o.first_col = (col_q == '0);
  assign cell_o.first_row = (row_q == '0);
  assign cell_o.border    = (row_q == '0) || (row_q >= last_row) ||
                            (col_q == '0) || row_end;
  assign cell_o.last      = lattice_end;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (lattice_end) begin
        row_d = '0;
        col_d = '0;
      end else if (row_end) begin
        row_d = row_q + ROW_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RESET;
      col_count_q <= COLUMN_COUNT_RESET;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ROW_COUNT:    row_count_q <= cfg_wdata_i;
          CFG_COLUMN_COUNT: col_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

>>> src/lss_fifo.sv
module lss_fifo import lss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  cell_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output cell_t pop_data_o
);

  cell_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != FIFO_CW'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + FIFO_PW'(1);
      if (pop)  rd_q <= rd_q + FIFO_PW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + FIFO_CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

>>> src/lss_back.sv
module lss_back import lss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cell_valid_i,
  output logic               cell_ready_o,
  input  cell_t              cell_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [DOWN_W-1:0]   res_down_o,
  output logic [BORDER_W-1:0] res_border_o,
  output logic [PAIRS_W-1:0]  res_pairs_o
);

  logic line_q [MAX_COLUMNS];

  cell_t               s1_q;
  logic                s1_valid_q;
  logic                above_q;
  logic                left_q;
  logic [DOWN_W-1:0]   down_q, down_d;
  logic [BORDER_W-1:0] border_q, border_d;
  logic [PAIRS_W-1:0]  pairs_q, pairs_d;
  logic                out_valid_q;
  logic [DOWN_W-1:0]   out_down_q;
  logic [BORDER_W-1:0] out_border_q;
  logic [PAIRS_W-1:0]  out_pairs_q;
  logic                fire, load, horiz, vert;

  assign fire = s1_valid_q && !(s1_q.last && out_valid_q && !res_ready_i);
  assign load = cell_valid_i && (!s1_valid_q || fire);
  assign cell_ready_o = load;

  assign horiz = !s1_q.first_col && (s1_q.spin != left_q);
  assign vert  = !s1_q.first_row && (s1_q.spin != above_q);

  always_comb begin
    down_d   = down_q + DOWN_W'(s1_q.spin);
    border_d = border_q + BORDER_W'(s1_q.spin && s1_q.border);
    pairs_d  = pairs_q + PAIRS_W'(horiz) + PAIRS_W'(vert);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      left_q      <= 1'b0;
      down_q      <= '0;
      border_q    <= '0;
      pairs_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        left_q <= s1_q.spin;
        if (s1_q.last) begin
          down_q   <= '0;
          border_q <= '0;
          pairs_q  <= '0;
        end else begin
          down_q   <= down_d;
          border_q <= border_d;
          pairs_q  <= pairs_d;
        end
      end
      if (fire && s1_q.last) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line buffer: read on load, write on fire; addresses never collide
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q    <= cell_i;
      above_q <= line_q[cell_i.col];
    end
    if (fire) begin
      line_q[s1_q.col] <= s1_q.spin;
    end
    if (fire && s1_q.last) begin
      out_down_q   <= down_d;
      out_border_q <= border_d;
      out_pairs_q  <= pairs_d;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_down_o   = out_down_q;
  assign res_border_o = out_border_q;
  assign res_pairs_o  = out_pairs_q;

endmodule

>>> src/lattice_spin_statistics.sv
// Spin statistics of a rectangular Ising lattice streamed one spin per beat in raster
// order. Row and column counts (2..1024, clamped) are to be set through the config port
// while idle; the block itself does not enforce this. At the last cell of each lattice
// one result beat gives the down spins, the down spins on the border and the adjacent
// unlike pairs. Throughput is one spin per clock while the result output is not held
// off: a front stage tracks the cell position and classifies each spin, a four-entry
// queue decouples it from the back stage, which reads the one-row line buffer (one read
// and one write per cycle), accumulates and holds the result in an output register.
// The last spin goes through the queue and the back-stage register to the result beat.
module lattice_spin_statistics import lss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [0] spin_down
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata    // down_count, border_down_count, unlike_pairs
);

  cell_t               f_cell, b_cell;
  logic                f_valid, f_ready, b_valid, b_ready;
  logic [DOWN_W-1:0]   res_down;
  logic [BORDER_W-1:0] res_border;
  logic [PAIRS_W-1:0]  res_pairs;

  lss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_spin_i    (s_axis_tdata[0]),
    .cell_valid_o (f_valid),
    .cell_ready_i (f_ready),
    .cell_o       (f_cell)
  );

  lss_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cell),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cell)
  );

  lss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (b_valid),
    .cell_ready_o (b_ready),
    .cell_i       (b_cell),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_down_o   (res_down),
    .res_border_o (res_border),
    .res_pairs_o  (res_pairs)
  );

  assign m_axis_tdata = {{(TDATA_W - RES_W){1'b0}}, res_pairs, res_border, res_down};

endmodule

>>> test/lattice_spin_statistics_tb.sv
`timescale 1ns / 100ps

module lattice_spin_statistics_tb;
  import lss_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_SPINS  = 560;

  // down in the low bits, as on m_axis_tdata
  typedef struct packed {
    logic [PAIRS_W-1:0]  pairs;
    logic [BORDER_W-1:0] border;
    logic [DOWN_W-1:0]   down;
  } counts_t;

  typedef struct packed {
    logic [3:0] spins;  // raster order, left to right
    counts_t    want;
  } lattice_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [IDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;   // [0] spin_down
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // down_count, border_down_count, unlike_pairs

  lattice_spin_statistics DUT (.*);

  always #2 clk_i = ~clk_i;

  // lattice model
  logic [CFG_W-1:0]    row_cfg = ROW_COUNT_RESET;
  logic [CFG_W-1:0]    col_cfg = COLUMN_COUNT_RESET;
  logic [ROW_W-1:0]    row_pos = '0;
  logic [COL_W-1:0]    col_pos = '0;
  bit                  line_buf [MAX_COLUMNS];
  int unsigned         buf_extent = 0;  // entries 0..buf_extent-1 written
  logic                left_spin = 1'b0;
  logic [DOWN_W-1:0]   down_acc = '0;
  logic [BORDER_W-1:0] border_acc = '0;
  logic [PAIRS_W-1:0]  pairs_acc = '0;

  counts_t     counts_q [$];
  int unsigned spins_sent = 0;
  int unsigned results_predicted = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_off_req = 1'b0;

  // 2x2 lattices, every cell on the border
  lattice_row_t directed_rows [6] = '{
    '{4'b0000, '{21'd0, 12'd0, 21'd0}},
    '{4'b1111, '{21'd0, 12'd4, 21'd4}},
    '{4'b1001, '{21'd4, 12'd2, 21'd2}},
    '{4'b0110, '{21'd4, 12'd2, 21'd2}},
    '{4'b1000, '{21'd2, 12'd1, 21'd1}},
    '{4'b0001, '{21'd2, 12'd1, 21'd1}}
  };

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  task automatic lattice_step(input logic spin, output bit done, output counts_t res);
    int unsigned last_row;
    int unsigned last_col;
    bit          row_end;
    bit          border;
    last_row = clamp_dim(row_cfg, MAX_ROWS) - 1;
    last_col = clamp_dim(col_cfg, MAX_COLUMNS) - 1;
    row_end  = col_pos >= last_col;
    done     = row_end && row_pos >= last_row;
    border   = row_pos == 0 || row_pos >= last_row || col_pos == 0 || col_pos >= last_col;
    if (spin) begin
      down_acc += 1'b1;
      if (border) border_acc += 1'b1;
    end
    if (col_pos != 0 && spin != left_spin) pairs_acc += 1'b1;
    if (row_pos != 0 && spin != line_buf[col_pos]) pairs_acc += 1'b1;
    line_buf[col_pos] = spin;
    if (col_pos + 1 > buf_extent) buf_extent = col_pos + 1;
    left_spin = spin;
    res = '{pairs_acc, border_acc, down_acc};
    if (done) begin
      row_pos    = '0;
      col_pos    = '0;
      left_spin  = 1'b0;
      down_acc   = '0;
      border_acc = '0;
      pairs_acc  = '0;
    end else if (row_end) begin
      col_pos = '0;
      row_pos += 1'b1;
    end else begin
      col_pos += 1'b1;
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned pick;
    if (!idle_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic biased_spin(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic send_spin(input logic spin, input bit typed, input counts_t want);
    int unsigned n;
    bit          done;
    counts_t     res;
    n = gap_len();
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, spin};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    spins_sent++;
    lattice_step(spin, done, res);
    if (done) begin
      counts_q.push_back(typed ? want : res);
      results_predicted++;
    end
  endtask

  task automatic settle();
    while (counts_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROW_COUNT;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    row_cfg = rows;
    cfg_index_i <= CFG_COLUMN_COUNT;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    col_cfg = cols;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                           input int unsigned lattices, input int unsigned pct,
                           input int unsigned tail, input bit hold);
    int unsigned goal;
    settle();
    // a mid-lattice column change must not reach unwritten line-buffer entries
    if (row_pos != 0 && clamp_dim(cols, MAX_COLUMNS) > buf_extent)
      cols = buf_extent[CFG_W-1:0];
    set_dims(rows, cols);
    hold_off_req = hold;
    goal = results_predicted + lattices;
    while (results_predicted < goal) send_spin(biased_spin(pct), 1'b0, '0);
    repeat (tail) send_spin(biased_spin(pct), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin : sink
    int unsigned n;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        n = gap_len();
        if (n == 0) begin
          m_axis_tready <= 1'b1;
          @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    counts_t got;
    counts_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_W-1:0];
      if (counts_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t unexpected result beat: down %0d border %0d pairs %0d",
                   $realtime, got.down, got.border, got.pairs);
      end else begin
        want = counts_q.pop_front();
        if (got.down !== want.down || got.border !== want.border ||
            got.pairs !== want.pairs) begin
          errors++;
          if (errors <= 10)
            $display("%0t result mismatch: down %0d/%0d border %0d/%0d pairs %0d/%0d (exp/got)",
                     $realtime, want.down, got.down, want.border, got.border,
                     want.pairs, got.pairs);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      pick;
    int unsigned      lattices;
    int unsigned      pct;
    int unsigned      tail;
    int unsigned      base_spins;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_ROW_COUNT;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both below range, clamped to 2x2
    set_dims(11'd1, 11'd0);
    foreach (directed_rows[i])
      for (int b = 3; b >= 0; b--)
        send_spin(directed_rows[i].spins[b], 1'b1, directed_rows[i].want);
    s_axis_tvalid <= 1'b0;

    run_phase(11'd2, 11'd2, 3, 50, 0, 1'b0);

    base_spins = spins_sent;
    phase      = 0;
    while (spins_sent < base_spins + RANDOM_SPINS) begin
      idle_on  = (phase % 5) != 4;
      rows     = CFG_W'($urandom_range(2, 5));
      cols     = CFG_W'($urandom_range(2, 7));
      lattices = $urandom_range(1, 6);
      tail     = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      pick     = $urandom_range(0, 9);
      pct      = (pick == 0) ? 0 : (pick == 1) ? 100 : (pick == 2) ? 10 :
                 (pick == 3) ? 90 : 50;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        rows = CFG_W'($urandom_range(0, 1));
      end else if (pick == 1) begin
        cols = CFG_W'($urandom_range(0, 1));
      end else if (pick == 2) begin
        // above the maximum, cut short by the next phase
        rows = 11'd2;
        cols = CFG_W'($urandom_range(1025, 2047));
        lattices = 0;
        tail = $urandom_range(1, 6);
      end else if (pick == 3) begin
        rows = CFG_W'($urandom_range(1025, 2047));
        cols = 11'd2;
        lattices = 0;
        tail = $urandom_range(1, 6);
      end else if (pick < 7) begin
        rows = CFG_W'($urandom_range(6, 12));
        cols = CFG_W'($urandom_range(8, 20));
        lattices = 1;
      end
      if (phase == 1) begin
        // output held off while small lattices keep coming
        idle_on = 1'b0;
        run_phase(11'd2, 11'd2, 30, 50, 0, 1'b1);
      end else begin
        run_phase(rows, cols, lattices, pct, tail, 1'b0);
      end
      phase++;
    end

    settle();
    if (errors == 0 && counts_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
